### rtl/hsd_pkg.sv
// hsd_pkg: constants, types and sequencer states for the hash set dedup block
// no dependencies; compile first
`default_nettype none

package hsd_pkg;

    localparam int TABLE_BITS = 10;
    localparam int KEY_W      = 64;
    localparam int HALF_W     = KEY_W / 2;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = TABLE_BITS + 1;

    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [TABLE_BITS-1:0] t_addr;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [INDEX_W-1:0]    t_index;
    typedef logic [HALF_W-1:0]     t_half;

    localparam t_key  FIB_MULT  = 64'h9E37_79B9_7F4A_7C15;
    localparam t_half FIB_LO    = FIB_MULT[HALF_W-1:0];
    localparam t_half FIB_HI    = FIB_MULT[KEY_W-1:HALF_W];
    localparam t_addr ADDR_LAST = {TABLE_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_RD,
        S_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/hsd_ifs.sv
// hsd_req_if and hsd_res_if: valid/ready channels for key requests and results
// depends on hsd_pkg
`default_nettype none

interface hsd_req_if;
    import hsd_pkg::*;

    logic valid;
    logic ready;
    t_key key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface hsd_res_if;
    import hsd_pkg::*;

    logic   valid;
    logic   ready;
    logic   is_new;
    t_index entry_index;
    logic   table_full;

    modport source (output valid, output is_new, output entry_index, output table_full,
                    input ready);
    modport sink   (input valid, input is_new, input entry_index, input table_full,
                    output ready);
endinterface

`default_nettype wire

### rtl/hash_set_insert_dedup.sv
// hash_set_insert_dedup: linear probing hash set with fibonacci hashing
// depends on hsd_pkg, hsd_ifs, hsd_mul, hsd_mem
//
//   channel   dir   handshake         payload
//   i_req     in    valid / ready     key
//   o_res     out   valid / ready     is_new, entry_index, table_full
//
// nonzero key: idle, then the hash states S_MUL0, S_MUL1, S_MUL2 and S_SUM (three partial
//   products on the shared multiplier, one sum), then a slot read (S_RD) and a compare
//   (S_CMP) per probe, up to 2**TABLE_BITS probes, then the result register (S_DONE)
// zero key: straight from idle to the result register, no probing
// after reset a clearing pass zeroes all 2**TABLE_BITS slots; i_req.ready stays low
// one request in flight; a waiting result holds the sequencer until taken
`default_nettype none

module hash_set_insert_dedup (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsd_req_if.sink   i_req,
    hsd_res_if.source o_res
);
    import hsd_pkg::*;

    t_state r_state, n_state;
    t_key   r_key, n_key;
    t_key   r_acc, n_acc;
    t_addr  r_pos, n_pos;
    t_addr  r_probes, n_probes;
    t_addr  r_clr, n_clr;
    t_count r_count, n_count;
    logic   r_new, n_new;
    t_index r_idx, n_idx;
    logic   r_full, n_full;
    logic   r_out_valid, n_out_valid;
    logic   r_o_new, n_o_new;
    t_index r_o_idx, n_o_idx;
    logic   r_o_full, n_o_full;

    t_half  mul_a, mul_b;
    t_key   mul_p;
    logic   mem_we;
    t_addr  mem_waddr, mem_raddr;
    t_key   mem_wdata, mem_rdata;
    t_key   hash_sum;
    logic   out_load;
    logic   hit_empty, hit_key, last_probe;

    hsd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    hsd_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign hash_sum   = r_acc + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
    assign hit_empty  = (mem_rdata == '0);
    assign hit_key    = (mem_rdata == r_key);
    assign last_probe = (r_probes == ADDR_LAST);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = (i_req.key == '0) ? S_DONE : S_MUL0;
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_RD;
            S_RD:   n_state = S_CMP;
            S_CMP: begin
                if (hit_empty || hit_key || last_probe) n_state = S_DONE;
                else n_state = S_RD;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
        endcase
    end

    // datapath and port controls
    always_comb begin
        n_key       = r_key;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_clr       = r_clr;
        n_count     = r_count;
        n_new       = r_new;
        n_idx       = r_idx;
        n_full      = r_full;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_new     = r_o_new;
        n_o_idx     = r_o_idx;
        n_o_full    = r_o_full;
        mul_a       = r_key[HALF_W-1:0];
        mul_b       = FIB_LO;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_key;
        mem_raddr   = r_pos;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key    = i_req.key;
                    n_new    = 1'b0;
                    n_idx    = '0;
                    n_full   = 1'b0;
                    n_probes = '0;
                end
            end
            S_MUL0: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = FIB_LO;
            end
            S_MUL1: begin
                mul_a = r_key[KEY_W-1:HALF_W];
                mul_b = FIB_LO;
                n_acc = mul_p;
            end
            S_MUL2: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = FIB_HI;
                n_acc = hash_sum;
            end
            S_SUM: begin
                n_pos = hash_sum[KEY_W-1 -: TABLE_BITS];
            end
            S_RD: begin
                mem_raddr = r_pos;
            end
            S_CMP: begin
                priority if (hit_empty) begin
                    mem_we  = 1'b1;
                    n_new   = 1'b1;
                    n_idx   = INDEX_W'(r_count);
                    n_count = r_count + 1'b1;
                end else if (hit_key) begin
                    n_new = 1'b0;
                end else if (last_probe) begin
                    n_full = 1'b1;
                end else begin
                    n_pos    = r_pos + 1'b1;
                    n_probes = r_probes + 1'b1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_o_new     = r_new;
                    n_o_idx     = r_idx;
                    n_o_full    = r_full;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_acc    <= n_acc;
        r_pos    <= n_pos;
        r_probes <= n_probes;
        r_new    <= n_new;
        r_idx    <= n_idx;
        r_full   <= n_full;
        r_o_new  <= n_o_new;
        r_o_idx  <= n_o_idx;
        r_o_full <= n_o_full;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.is_new      = r_o_new;
    assign o_res.entry_index = r_o_idx;
    assign o_res.table_full  = r_o_full;

endmodule

`default_nettype wire

### rtl/hsd_mul.sv
// hsd_mul: shared 32x32 multiplier with registered product
// depends on hsd_pkg
`default_nettype none

module hsd_mul (
    input  logic                          i_clk,
    input  logic [hsd_pkg::HALF_W-1:0]    i_a,
    input  logic [hsd_pkg::HALF_W-1:0]    i_b,
    output logic [hsd_pkg::KEY_W-1:0]     o_p
);
    import hsd_pkg::*;

    t_key r_p;

    always_ff @(posedge i_clk) begin
        r_p <= KEY_W'(i_a) * KEY_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/hsd_mem.sv
// hsd_mem: slot store, one write port and one registered read port
// depends on hsd_pkg
`default_nettype none

module hsd_mem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [hsd_pkg::TABLE_BITS-1:0]    i_waddr,
    input  logic [hsd_pkg::KEY_W-1:0]         i_wdata,
    input  logic [hsd_pkg::TABLE_BITS-1:0]    i_raddr,
    output logic [hsd_pkg::KEY_W-1:0]         o_rdata
);
    import hsd_pkg::*;

    t_key r_mem [2**TABLE_BITS];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/hsd_checker.sv
// hsd_checker: port-level assertions for hash_set_insert_dedup, bound to the top level
// depends on hsd_pkg
`default_nettype none

module hsd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           o_res_valid,
    input logic                           o_res_ready,
    input logic                           o_res_is_new,
    input logic [hsd_pkg::INDEX_W-1:0]    o_res_entry_index,
    input logic                           o_res_table_full
);
    import hsd_pkg::*;

    // one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while previous request in progress");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_ready |=>
            o_res_valid && $stable(o_res_is_new) && $stable(o_res_entry_index)
            && $stable(o_res_table_full))
        else $error("stalled result changed");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res_is_new && o_res_table_full))
        else $error("result both new and full");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_is_new |-> o_res_entry_index == '0)
        else $error("nonzero index on result that is not new");

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_req_ready)
        else $error("ready during clearing pass");

endmodule

bind hash_set_insert_dedup hsd_checker u_hsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .o_res_valid       (o_res.valid),
    .o_res_ready       (o_res.ready),
    .o_res_is_new      (o_res.is_new),
    .o_res_entry_index (o_res.entry_index),
    .o_res_table_full  (o_res.table_full)
);

`default_nettype wire
